/* rtl/qvr_pkg.sv */
// shared types, widths and arithmetic helpers for the quaternion vector rotator
`default_nettype none

package qvr_pkg;

    localparam int Q_W    = 16;              // quaternion component, Q2.14
    localparam int V_W    = 24;              // vector coordinate
    localparam int PV_W   = Q_W + V_W;       // q * v product
    localparam int P_W    = PV_W + 2;        // sum of three q * v products
    localparam int PQ_W   = P_W + Q_W;       // p * q product
    localparam int ACC_W  = PQ_W + 3;        // sum of four products plus rounding
    localparam int SHIFT  = 28;
    localparam int SH_W   = ACC_W - SHIFT;   // accumulator after the scale shift
    localparam int DATA_W = 3 * V_W;
    localparam int IDX_W  = 2;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(2 ** (SHIFT - 1));
    localparam logic signed [V_W-1:0]   V_MAX      = {1'b0, {(V_W - 1){1'b1}}};
    localparam logic signed [V_W-1:0]   V_MIN      = {1'b1, {(V_W - 1){1'b0}}};
    localparam logic signed [Q_W-1:0]   QUAT_W_RST = Q_W'(16384);

    typedef enum logic [IDX_W-1:0] {
        REG_QUAT_X = 2'd0,
        REG_QUAT_Y = 2'd1,
        REG_QUAT_Z = 2'd2,
        REG_QUAT_W = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [Q_W-1:0] w;
        logic signed [Q_W-1:0] z;
        logic signed [Q_W-1:0] y;
        logic signed [Q_W-1:0] x;
    } quat_t;

    // x in the lowest bits, matching the stream packing
    typedef struct packed {
        logic signed [V_W-1:0] z;
        logic signed [V_W-1:0] y;
        logic signed [V_W-1:0] x;
    } vec_t;

    typedef struct packed {
        logic signed [P_W-1:0] w;
        logic signed [P_W-1:0] z;
        logic signed [P_W-1:0] y;
        logic signed [P_W-1:0] x;
    } pquat_t;

    typedef struct packed {
        logic signed [SH_W-1:0] z;
        logic signed [SH_W-1:0] y;
        logic signed [SH_W-1:0] x;
    } shvec_t;

    // load enables for the two register stages of one unit
    typedef struct packed {
        logic en_a;
        logic en_b;
    } stg_ctl_t;

    function automatic logic signed [PV_W-1:0] mul_qv(
        input logic signed [Q_W-1:0] a,
        input logic signed [V_W-1:0] b
    );
        return PV_W'(a) * PV_W'(b);
    endfunction

    function automatic logic signed [PQ_W-1:0] mul_pq(
        input logic signed [P_W-1:0] a,
        input logic signed [Q_W-1:0] b
    );
        return PQ_W'(a) * PQ_W'(b);
    endfunction

endpackage

`default_nettype wire

/* rtl/quaternion_vector_rotate.sv */
// quaternion vector rotator top level: valid pipeline and stage wiring
//
// Rotates each vector v on the slave stream by the quaternion q held in four
// registers, giving the vector part of q * v * conj(q) scaled back by 2^28
// with round half up and saturated to 24 bits.
// Slave stream: s_tdata carries vec_x, vec_y, vec_z from the lowest bit up.
// Master stream: m_tdata carries rot_x, rot_y, rot_z; m_tuser[0] is the
// saturation flag, set when any coordinate was clamped.
// Configuration: cfg_index 0..3 selects quat_x, quat_y, quat_z, quat_w;
// cfg_ready is always high. Write only while no vector is in flight.
// Pipeline: five register stages (q*v products, p sums, p*conj(q) products,
// round-and-shift sums, saturation and output register).
// Throughput: one vector per cycle while the receiver does not stall.
// Reset clears all valid bits and loads the identity quaternion (w = 1.0).
// When the receiver stalls, the stages ahead of a bubble keep moving; once
// every stage is full s_tready drops and nothing is lost or repeated.
`default_nettype none

module quaternion_vector_rotate (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [qvr_pkg::DATA_W-1:0] s_tdata,   // vec_x, vec_y, vec_z
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [qvr_pkg::DATA_W-1:0]      m_tdata,   // rot_x, rot_y, rot_z
    output logic [0:0]                      m_tuser,   // clipped
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [qvr_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [qvr_pkg::Q_W-1:0]    cfg_data
);

    localparam int STAGES = 5;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] en;

    qvr_pkg::quat_t    quat;
    qvr_pkg::pquat_t   prod;
    qvr_pkg::shvec_t   scaled;
    qvr_pkg::vec_t     rot;
    qvr_pkg::stg_ctl_t pmul_ctl;
    qvr_pkg::stg_ctl_t cmul_ctl;
    logic              clipped;

    // a stage loads when it is empty or its contents move on
    always_comb
    begin
        en[STAGES-1] = !vld_reg[STAGES-1] || m_tready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = s_tvalid;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (en[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready      = en[0];
    assign pmul_ctl.en_a = en[0];
    assign pmul_ctl.en_b = en[1];
    assign cmul_ctl.en_a = en[2];
    assign cmul_ctl.en_b = en[3];

    qvr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .quat      (quat)
    );

    qvr_pmul u_pmul (
        .clk  (clk),
        .ctl  (pmul_ctl),
        .quat (quat),
        .vec  (qvr_pkg::vec_t'(s_tdata)),
        .prod (prod)
    );

    qvr_cmul u_cmul (
        .clk    (clk),
        .ctl    (cmul_ctl),
        .quat   (quat),
        .prod   (prod),
        .scaled (scaled)
    );

    qvr_sat u_sat (
        .clk     (clk),
        .en      (en[STAGES-1]),
        .scaled  (scaled),
        .rot     (rot),
        .clipped (clipped)
    );

    assign m_tvalid   = vld_reg[STAGES-1];
    assign m_tdata    = rot;
    assign m_tuser[0] = clipped;

endmodule

`default_nettype wire

/* rtl/qvr_cfg.sv */
// rotation quaternion register file
`default_nettype none

module qvr_cfg (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [qvr_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [qvr_pkg::Q_W-1:0]   cfg_data,
    output qvr_pkg::quat_t                 quat
);

    qvr_pkg::quat_t   quat_reg;
    qvr_pkg::quat_t   quat_next;
    qvr_pkg::cfg_reg_t idx;

    assign cfg_ready = 1'b1;
    assign idx       = qvr_pkg::cfg_reg_t'(cfg_index);

    always_comb
    begin
        quat_next = quat_reg;
        if (cfg_valid)
        begin
            unique case (idx)
                qvr_pkg::REG_QUAT_X: quat_next.x = cfg_data;
                qvr_pkg::REG_QUAT_Y: quat_next.y = cfg_data;
                qvr_pkg::REG_QUAT_Z: quat_next.z = cfg_data;
                qvr_pkg::REG_QUAT_W: quat_next.w = cfg_data;
                default:             quat_next   = quat_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_reg.x <= '0;
            quat_reg.y <= '0;
            quat_reg.z <= '0;
            quat_reg.w <= qvr_pkg::QUAT_W_RST;
        end
        else
        begin
            quat_reg <= quat_next;
        end
    end

    assign quat = quat_reg;

endmodule

`default_nettype wire

/* rtl/qvr_pmul.sv */
// first product p = q * v: partial products, then the four sums
`default_nettype none

module qvr_pmul (
    input  wire logic                   clk,
    input  wire qvr_pkg::stg_ctl_t      ctl,
    input  wire qvr_pkg::quat_t         quat,
    input  wire qvr_pkg::vec_t          vec,
    output qvr_pkg::pquat_t             prod
);

    logic signed [qvr_pkg::PV_W-1:0] xvx_reg, yvy_reg, zvz_reg;
    logic signed [qvr_pkg::PV_W-1:0] wvx_reg, yvz_reg, zvy_reg;
    logic signed [qvr_pkg::PV_W-1:0] wvy_reg, zvx_reg, xvz_reg;
    logic signed [qvr_pkg::PV_W-1:0] wvz_reg, xvy_reg, yvx_reg;
    qvr_pkg::pquat_t                 p_reg;
    qvr_pkg::pquat_t                 p_next;

    always_ff @(posedge clk)
    begin
        if (ctl.en_a)
        begin
            xvx_reg <= qvr_pkg::mul_qv(quat.x, vec.x);
            yvy_reg <= qvr_pkg::mul_qv(quat.y, vec.y);
            zvz_reg <= qvr_pkg::mul_qv(quat.z, vec.z);
            wvx_reg <= qvr_pkg::mul_qv(quat.w, vec.x);
            yvz_reg <= qvr_pkg::mul_qv(quat.y, vec.z);
            zvy_reg <= qvr_pkg::mul_qv(quat.z, vec.y);
            wvy_reg <= qvr_pkg::mul_qv(quat.w, vec.y);
            zvx_reg <= qvr_pkg::mul_qv(quat.z, vec.x);
            xvz_reg <= qvr_pkg::mul_qv(quat.x, vec.z);
            wvz_reg <= qvr_pkg::mul_qv(quat.w, vec.z);
            xvy_reg <= qvr_pkg::mul_qv(quat.x, vec.y);
            yvx_reg <= qvr_pkg::mul_qv(quat.y, vec.x);
        end
    end

    // scalar part is minus the dot product
    always_comb
    begin
        p_next.w = qvr_pkg::P_W'(0) - qvr_pkg::P_W'(xvx_reg)
                 - qvr_pkg::P_W'(yvy_reg) - qvr_pkg::P_W'(zvz_reg);
        p_next.x = qvr_pkg::P_W'(wvx_reg) + qvr_pkg::P_W'(yvz_reg)
                 - qvr_pkg::P_W'(zvy_reg);
        p_next.y = qvr_pkg::P_W'(wvy_reg) + qvr_pkg::P_W'(zvx_reg)
                 - qvr_pkg::P_W'(xvz_reg);
        p_next.z = qvr_pkg::P_W'(wvz_reg) + qvr_pkg::P_W'(xvy_reg)
                 - qvr_pkg::P_W'(yvx_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_b)
        begin
            p_reg <= p_next;
        end
    end

    assign prod = p_reg;

endmodule

`default_nettype wire

/* rtl/qvr_cmul.sv */
// second product p * conj(q): partial products, then sums with rounding and scale shift
`default_nettype none

module qvr_cmul (
    input  wire logic                   clk,
    input  wire qvr_pkg::stg_ctl_t      ctl,
    input  wire qvr_pkg::quat_t         quat,
    input  wire qvr_pkg::pquat_t        prod,
    output qvr_pkg::shvec_t             scaled
);

    logic signed [qvr_pkg::PQ_W-1:0] xw_reg, wx_reg, yz_reg, zy_reg;
    logic signed [qvr_pkg::PQ_W-1:0] yw_reg, wy_reg, zx_reg, xz_reg;
    logic signed [qvr_pkg::PQ_W-1:0] zw_reg, wz_reg, xy_reg, yx_reg;
    logic signed [qvr_pkg::ACC_W-1:0] acc_x, acc_y, acc_z;
    qvr_pkg::shvec_t                  sh_reg;
    qvr_pkg::shvec_t                  sh_next;

    // operand order is p component times q component
    always_ff @(posedge clk)
    begin
        if (ctl.en_a)
        begin
            xw_reg <= qvr_pkg::mul_pq(prod.x, quat.w);
            wx_reg <= qvr_pkg::mul_pq(prod.w, quat.x);
            yz_reg <= qvr_pkg::mul_pq(prod.y, quat.z);
            zy_reg <= qvr_pkg::mul_pq(prod.z, quat.y);
            yw_reg <= qvr_pkg::mul_pq(prod.y, quat.w);
            wy_reg <= qvr_pkg::mul_pq(prod.w, quat.y);
            zx_reg <= qvr_pkg::mul_pq(prod.z, quat.x);
            xz_reg <= qvr_pkg::mul_pq(prod.x, quat.z);
            zw_reg <= qvr_pkg::mul_pq(prod.z, quat.w);
            wz_reg <= qvr_pkg::mul_pq(prod.w, quat.z);
            xy_reg <= qvr_pkg::mul_pq(prod.x, quat.y);
            yx_reg <= qvr_pkg::mul_pq(prod.y, quat.x);
        end
    end

    // conjugate folded into the signs, round half up before the floor shift
    always_comb
    begin
        acc_x = qvr_pkg::ACC_W'(xw_reg) - qvr_pkg::ACC_W'(wx_reg)
              - qvr_pkg::ACC_W'(yz_reg) + qvr_pkg::ACC_W'(zy_reg) + qvr_pkg::ROUND_BIAS;
        acc_y = qvr_pkg::ACC_W'(yw_reg) - qvr_pkg::ACC_W'(wy_reg)
              - qvr_pkg::ACC_W'(zx_reg) + qvr_pkg::ACC_W'(xz_reg) + qvr_pkg::ROUND_BIAS;
        acc_z = qvr_pkg::ACC_W'(zw_reg) - qvr_pkg::ACC_W'(wz_reg)
              - qvr_pkg::ACC_W'(xy_reg) + qvr_pkg::ACC_W'(yx_reg) + qvr_pkg::ROUND_BIAS;
        sh_next.x = acc_x[qvr_pkg::ACC_W-1:qvr_pkg::SHIFT];
        sh_next.y = acc_y[qvr_pkg::ACC_W-1:qvr_pkg::SHIFT];
        sh_next.z = acc_z[qvr_pkg::ACC_W-1:qvr_pkg::SHIFT];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_b)
        begin
            sh_reg <= sh_next;
        end
    end

    assign scaled = sh_reg;

endmodule

`default_nettype wire

/* rtl/qvr_sat.sv */
// saturation to the coordinate width and the output register
`default_nettype none

module qvr_sat (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire qvr_pkg::shvec_t  scaled,
    output qvr_pkg::vec_t         rot,
    output logic                  clipped
);

    localparam logic signed [qvr_pkg::SH_W-1:0] HI = qvr_pkg::SH_W'(qvr_pkg::V_MAX);
    localparam logic signed [qvr_pkg::SH_W-1:0] LO = qvr_pkg::SH_W'(qvr_pkg::V_MIN);

    qvr_pkg::vec_t rot_reg;
    qvr_pkg::vec_t rot_next;
    logic          clip_reg;
    logic          clip_next;
    logic [2:0]    hi_x;
    logic [2:0]    lo_x;

    always_comb
    begin
        hi_x = {scaled.z > HI, scaled.y > HI, scaled.x > HI};
        lo_x = {scaled.z < LO, scaled.y < LO, scaled.x < LO};

        rot_next.x = hi_x[0] ? qvr_pkg::V_MAX :
                     lo_x[0] ? qvr_pkg::V_MIN : scaled.x[qvr_pkg::V_W-1:0];
        rot_next.y = hi_x[1] ? qvr_pkg::V_MAX :
                     lo_x[1] ? qvr_pkg::V_MIN : scaled.y[qvr_pkg::V_W-1:0];
        rot_next.z = hi_x[2] ? qvr_pkg::V_MAX :
                     lo_x[2] ? qvr_pkg::V_MIN : scaled.z[qvr_pkg::V_W-1:0];
        clip_next  = |{hi_x, lo_x};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot_reg  <= rot_next;
            clip_reg <= clip_next;
        end
    end

    assign rot     = rot_reg;
    assign clipped = clip_reg;

endmodule

`default_nettype wire

/* rtl/qvr_checker.sv */
// port-level checks for the quaternion vector rotator, bound to the top level
`default_nettype none

module qvr_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       s_tready,
    input wire logic                       m_tvalid,
    input wire logic                       m_tready,
    input wire logic [qvr_pkg::DATA_W-1:0] m_tdata,
    input wire logic [0:0]                 m_tuser
);

    localparam int VW = qvr_pkg::V_W;

    // a stalled transaction stays on offer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("output payload changed while stalled");

    // with the output empty every stage can advance
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output");

    // saturation flag implies a clamped coordinate
    a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |->
            m_tdata[VW-1:0] == qvr_pkg::V_MAX || m_tdata[VW-1:0] == qvr_pkg::V_MIN ||
            m_tdata[2*VW-1:VW] == qvr_pkg::V_MAX || m_tdata[2*VW-1:VW] == qvr_pkg::V_MIN ||
            m_tdata[3*VW-1:2*VW] == qvr_pkg::V_MAX ||
            m_tdata[3*VW-1:2*VW] == qvr_pkg::V_MIN)
        else $error("clipped set without a saturated coordinate");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (.*);

`default_nettype wire
